### rtl/lscp_pkg.sv
package lscp_pkg;

   localparam int MAX_CHANNELS = 16;
   localparam int FULL_SCALE   = 1000;
   localparam int ADDR_W       = $clog2(MAX_CHANNELS);
   localparam int FS_W         = $clog2(FULL_SCALE + 1);
   localparam int MAG_W        = 33;
   localparam int PROD_W       = MAG_W + FS_W;
   localparam int WSUM_W       = 28;
   localparam int WGT_W        = 14;
   localparam int POS_W        = 14;
   localparam int PV_W         = 10;
   localparam int CNT_W        = 5;

   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

   localparam logic KIND_CAL     = 1'b0;
   localparam logic KIND_MEASURE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [3:0]        channel;
      logic signed [31:0] reading;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_channel;
      logic signed [31:0] chan_max;
      logic signed [31:0] chan_min;
      logic [PV_W-1:0]    processed_value;
      logic [POS_W-1:0]   line_position;
      logic               is_position;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] max_val;
      logic signed [31:0] min_val;
   } cal_entry_type;

   typedef struct packed {
      logic [MAG_W-1:0]  rem_init;
      logic [WSUM_W-1:0] bits;
      logic [MAG_W-1:0]  divisor;
      logic [CNT_W-1:0]  count;
   } div_cmd_type;

endpackage

### rtl/lscp_cal_ram.sv
module lscp_cal_ram
   import lscp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  cal_entry_type       wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output cal_entry_type       rd_data
);

   cal_entry_type             mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]   valid_ff;
   cal_entry_type             rd_data_ff;
   logic                      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_data_ff;
      end else begin
         rd_data.max_val = INT_MIN;
         rd_data.min_val = INT_MAX;
      end
   end

endmodule

### rtl/lscp_divider.sv
module lscp_divider
   import lscp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  div_cmd_type       cmd,
   output logic              done,
   output logic [WSUM_W-1:0] quotient
);

   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [WSUM_W-1:0] bits_ff, bits_in;
   logic [WSUM_W-1:0] quo_ff, quo_in;
   logic [MAG_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MAG_W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, bits_ff[WSUM_W-1]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = cmd.rem_init;
         bits_in = cmd.bits;
         quo_in  = '0;
         cnt_in  = cmd.count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[MAG_W]) begin
            rem_in = trial[MAG_W-1:0];
         end else begin
            rem_in = {rem_ff[MAG_W-2:0], bits_ff[WSUM_W-1]};
         end
         quo_in  = {quo_ff[WSUM_W-2:0], !trial[MAG_W]};
         bits_in = {bits_ff[WSUM_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      if (start) begin
         dvs_ff <= cmd.divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/line_sensor_calibrated_position_top.sv
// Calibration item: RAM read, then write back in S_READ, no result.
// Measurement item: value result leaves from S_VAL, via S_READ alone without
// a divide, else after S_MUL, S_DSTART, S_DWAIT (serial divide, one quotient
// bit a cycle); frame_end adds a position, via S_PWAIT for a nonzero sum.
// One item in flight; results leave through a one-deep output register.
// Synchronous reset: extremes read as reset values until written, sums clear.
module line_sensor_calibrated_position_top
   import lscp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_MUL, S_DSTART, S_DWAIT, S_VAL, S_PSTART, S_PWAIT, S_POS
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   logic [4:0]         num_ch_ff;
   logic signed [31:0] mx_ff, mn_ff;
   logic [MAG_W-1:0]   na_ff, da_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PV_W-1:0]    p_ff;
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [WGT_W-1:0]   wgt_ff, wgt_in;
   logic [POS_W-1:0]   pos_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   cal_entry_type      rd_data, wr_data;
   logic               ram_we, ram_re;
   logic               accept, slot_free, ignore, rsp_load;
   logic               div_start, div_done;
   div_cmd_type        div_cmd;
   logic [WSUM_W-1:0]  div_q;

   logic signed [MAG_W-1:0] nd, dd;
   logic [MAG_W-1:0]        na, da;
   logic [4:0]              nclamp;
   logic [POS_W-1:0]        pos_zero, pos_sat;
   logic [PV_W-1:0]         p_direct;
   logic                    use_div;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = ((state_ff == S_VAL) || (state_ff == S_POS)) && slot_free;
   assign ignore    = (32'(req_data.channel) >= 32'(MAX_CHANNELS));
   assign ram_re    = accept;
   assign ram_we    = (state_ff == S_READ) && (req_ff.kind == KIND_CAL);

   always_comb begin
      wr_data.max_val = (req_ff.reading > rd_data.max_val) ? req_ff.reading : rd_data.max_val;
      wr_data.min_val = (req_ff.reading < rd_data.min_val) ? req_ff.reading : rd_data.min_val;
   end

   lscp_cal_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(req_ff.channel)),
      .wr_data (wr_data),
      .rd_en   (ram_re),
      .rd_addr (ADDR_W'(req_data.channel)),
      .rd_data (rd_data)
   );

   // classification of the normalised value
   always_comb begin
      nd = {req_ff.reading[31], req_ff.reading} - {rd_data.min_val[31], rd_data.min_val};
      dd = {rd_data.max_val[31], rd_data.max_val} - {rd_data.min_val[31], rd_data.min_val};
      na = nd[MAG_W-1] ? MAG_W'(-nd) : MAG_W'(nd);
      da = dd[MAG_W-1] ? MAG_W'(-dd) : MAG_W'(dd);
      use_div  = 1'b0;
      p_direct = PV_W'(FULL_SCALE);
      if (dd == '0) begin
         p_direct = (req_ff.reading <= rd_data.min_val) ? PV_W'(FULL_SCALE) : '0;
      end else if ((nd == '0) || (nd[MAG_W-1] != dd[MAG_W-1])) begin
         p_direct = PV_W'(FULL_SCALE);
      end else if (na >= da) begin
         p_direct = '0;
      end else begin
         use_div = 1'b1;
      end
   end

   always_comb begin
      div_start = (state_ff == S_DSTART) || ((state_ff == S_PSTART) && (wgt_ff != '0));
      if (state_ff == S_PSTART) begin
         div_cmd.rem_init = '0;
         div_cmd.bits     = wsum_ff;
         div_cmd.divisor  = MAG_W'(wgt_ff);
         div_cmd.count    = CNT_W'(WSUM_W);
      end else begin
         div_cmd.rem_init = prod_ff[PROD_W-1:FS_W];
         div_cmd.bits     = {prod_ff[FS_W-1:0], (WSUM_W-FS_W)'(0)};
         div_cmd.divisor  = da_ff;
         div_cmd.count    = CNT_W'(FS_W);
      end
   end

   lscp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      wsum_in = wsum_ff + WSUM_W'(32'(p_ff) * 32'(req_ff.channel) * FULL_SCALE);
      wgt_in  = wgt_ff + WGT_W'(p_ff);
      if (num_ch_ff == '0) begin
         nclamp = 5'd1;
      end else if (32'(num_ch_ff) > MAX_CHANNELS) begin
         nclamp = 5'(MAX_CHANNELS);
      end else begin
         nclamp = num_ch_ff;
      end
      pos_zero = POS_W'(((32'(nclamp) - 1) * FULL_SCALE) / 2);
      pos_sat  = (div_q > WSUM_W'({POS_W{1'b1}})) ? {POS_W{1'b1}} : div_q[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_ch_ff    <= 5'd8;
         wsum_ff      <= '0;
         wgt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            num_ch_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff <= req_data;
                  if (!ignore) begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               mx_ff <= rd_data.max_val;
               mn_ff <= rd_data.min_val;
               na_ff <= na;
               da_ff <= da;
               p_ff  <= p_direct;
               if (req_ff.kind == KIND_CAL) begin
                  state_ff <= S_IDLE;
               end else if (use_div) begin
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_VAL;
               end
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(na_ff) * PROD_W'(FULL_SCALE);
               state_ff <= S_DSTART;
            end
            S_DSTART: begin
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (div_done) begin
                  p_ff     <= PV_W'(FULL_SCALE) - div_q[PV_W-1:0];
                  state_ff <= S_VAL;
               end
            end
            S_VAL: begin
               if (slot_free) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.out_channel     <= req_ff.channel;
                  rsp_data_ff.chan_max        <= mx_ff;
                  rsp_data_ff.chan_min        <= mn_ff;
                  rsp_data_ff.processed_value <= p_ff;
                  rsp_data_ff.line_position   <= '0;
                  rsp_data_ff.is_position     <= 1'b0;
                  rsp_data_ff.last            <= !req_ff.frame_end;
                  wsum_ff <= wsum_in;
                  wgt_ff  <= wgt_in;
                  state_ff <= req_ff.frame_end ? S_PSTART : S_IDLE;
               end
            end
            S_PSTART: begin
               if (wgt_ff == '0) begin
                  pos_ff   <= pos_zero;
                  state_ff <= S_POS;
               end else begin
                  state_ff <= S_PWAIT;
               end
            end
            S_PWAIT: begin
               if (div_done) begin
                  pos_ff   <= pos_sat;
                  state_ff <= S_POS;
               end
            end
            S_POS: begin
               if (slot_free) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.out_channel     <= '0;
                  rsp_data_ff.chan_max        <= '0;
                  rsp_data_ff.chan_min        <= '0;
                  rsp_data_ff.processed_value <= '0;
                  rsp_data_ff.line_position   <= pos_ff;
                  rsp_data_ff.is_position     <= 1'b1;
                  rsp_data_ff.last            <= 1'b1;
                  wsum_ff  <= '0;
                  wgt_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sim/line_sensor_calibrated_position_top_tb.sv
`timescale 1ns / 1ps

module line_sensor_calibrated_position_top_tb;
   import lscp_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [4:0] csr_wdata;

   line_sensor_calibrated_position_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic signed [31:0] cal_max [MAX_CHANNELS];
   logic signed [31:0] cal_min [MAX_CHANNELS];
   logic [WSUM_W-1:0]  acc_weighted;
   logic [WGT_W-1:0]   acc_weight;
   logic [4:0]         chan_count;

   rsp_type expected_rsps[$];
   int  n_errors = 0;
   int  n_items = 0;
   int  n_rsps = 0;
   int  n_positions = 0;
   int  idle_cycles = 0;
   bit  calm = 0;
   bit  hold_off = 0;
   int  hold_cycles = 0;
   int  stall_left = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic logic [PV_W-1:0] scaled_darkness(logic signed [31:0] v,
                                                       logic signed [31:0] mn,
                                                       logic signed [31:0] mx);
      longint s;
      if (mx == mn) s = (v <= mn) ? 0 : FULL_SCALE;
      else s = ((longint'(v) - longint'(mn)) * FULL_SCALE) / (longint'(mx) - longint'(mn));
      if (s < 0) s = 0;
      if (s > FULL_SCALE) s = FULL_SCALE;
      return PV_W'(FULL_SCALE - s);
   endfunction

   task automatic predict_item(req_type it);
      rsp_type r;
      logic [PV_W-1:0] p;
      longint pos, n;
      if (it.kind == KIND_CAL) begin
         if (it.reading > cal_max[it.channel]) cal_max[it.channel] = it.reading;
         if (it.reading < cal_min[it.channel]) cal_min[it.channel] = it.reading;
         return;
      end
      p = scaled_darkness(it.reading, cal_min[it.channel], cal_max[it.channel]);
      acc_weighted = WSUM_W'(longint'(acc_weighted) + longint'(p) * it.channel * FULL_SCALE);
      acc_weight   = WGT_W'(acc_weight + p);
      r = '0;
      r.out_channel = it.channel;
      r.chan_max = cal_max[it.channel];
      r.chan_min = cal_min[it.channel];
      r.processed_value = p;
      r.last = !it.frame_end;
      expected_rsps.push_back(r);
      if (it.frame_end) begin
         if (acc_weight == 0) begin
            n = chan_count;
            if (n < 1) n = 1;
            if (n > MAX_CHANNELS) n = MAX_CHANNELS;
            pos = (n - 1) * FULL_SCALE / 2;
         end else pos = longint'(acc_weighted) / longint'(acc_weight);
         if (pos > 16383) pos = 16383;
         acc_weighted = '0;
         acc_weight = '0;
         r = '0;
         r.line_position = POS_W'(pos);
         r.is_position = 1'b1;
         r.last = 1'b1;
         expected_rsps.push_back(r);
      end
   endtask

   // valid stays high into the next call; drain takes it low
   task automatic send_item(logic kind, logic [3:0] ch, logic signed [31:0] v, logic fe);
      req_type it;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      it.kind = kind; it.channel = ch; it.reading = v; it.frame_end = fe;
      req_data <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_item(it);
      n_items++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_channels(logic [4:0] val);
      csr_we <= 1'b1;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      chan_count = val;
   endtask

   function automatic logic signed [31:0] rand_reading();
      case ($urandom_range(0, 5))
         0: return INT_MIN;
         1: return INT_MAX;
         2: return $signed($urandom());
         default: return $signed(32'($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   task automatic test_directed();
      send_item(KIND_MEASURE, 4'd0, 32'sd5, 1'b0);
      send_item(KIND_MEASURE, 4'd3, 32'sd5, 1'b1);
      send_item(KIND_CAL, 4'd1, 32'sd100, 1'b1);
      send_item(KIND_MEASURE, 4'd1, 32'sd100, 1'b0);
      send_item(KIND_MEASURE, 4'd1, 32'sd101, 1'b0);
      send_item(KIND_MEASURE, 4'd1, 32'sd99, 1'b1);
      send_item(KIND_CAL, 4'd15, INT_MIN, 1'b0);
      send_item(KIND_CAL, 4'd15, INT_MAX, 1'b0);
      send_item(KIND_MEASURE, 4'd15, INT_MIN, 1'b0);
      send_item(KIND_MEASURE, 4'd15, INT_MAX, 1'b0);
      send_item(KIND_MEASURE, 4'd15, 32'sd0, 1'b1);
      send_item(KIND_CAL, 4'd2, -32'sd50, 1'b0);
      send_item(KIND_CAL, 4'd2, 32'sd50, 1'b0);
      send_item(KIND_MEASURE, 4'd2, -32'sd60, 1'b0);
      send_item(KIND_MEASURE, 4'd2, 32'sd60, 1'b0);
      send_item(KIND_MEASURE, 4'd2, 32'sd7, 1'b1);
      send_item(KIND_MEASURE, 4'd12, 32'sd7, 1'b1);
      drain();
   endtask

   task automatic test_channel_counts();
      logic [4:0] vals [5] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd8};
      foreach (vals[i]) begin
         write_channels(vals[i]);
         send_item(KIND_MEASURE, 4'd1, 32'sd1000, 1'b1);
         drain();
      end
   endtask

   // mostly calibrate-then-frame sequences, some noise
   task automatic test_random_frames(int n);
      int cnt, nch;
      cnt = 0;
      while (cnt < n) begin
         nch = $urandom_range(1, 16);
         if ($urandom_range(0, 3) == 0) begin
            send_item(1'($urandom()), 4'($urandom()), rand_reading(), 1'($urandom()));
            cnt++;
         end else begin
            for (int c = 0; c < nch; c++) begin
               send_item(KIND_CAL, 4'(c), rand_reading(), 1'($urandom()));
               cnt++;
            end
            for (int c = 0; c < nch; c++) begin
               send_item(KIND_MEASURE, 4'(c), rand_reading(), c == nch - 1);
               cnt++;
            end
         end
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      hold_off = 1;
      for (int i = 0; i < 20; i++)
         send_item(KIND_MEASURE, 4'($urandom()), rand_reading(), 1'($urandom()));
      drain();
   endtask

   // receiver
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_ready <= 1'b0;
         if (hold_cycles == 0) hold_off <= 1'b0;
         else hold_cycles <= hold_cycles - 1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsps++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected item %p", rsp_data);
            n_errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (e.is_position) n_positions++;
            if (rsp_data.out_channel !== e.out_channel) begin
               $error("out_channel exp %0d got %0d", e.out_channel, rsp_data.out_channel);
               n_errors++;
            end
            if (rsp_data.chan_max !== e.chan_max) begin
               $error("chan_max exp %0d got %0d", e.chan_max, rsp_data.chan_max);
               n_errors++;
            end
            if (rsp_data.chan_min !== e.chan_min) begin
               $error("chan_min exp %0d got %0d", e.chan_min, rsp_data.chan_min);
               n_errors++;
            end
            if (rsp_data.processed_value !== e.processed_value) begin
               $error("processed_value exp %0d got %0d", e.processed_value,
                      rsp_data.processed_value);
               n_errors++;
            end
            if (rsp_data.line_position !== e.line_position) begin
               $error("line_position exp %0d got %0d", e.line_position,
                      rsp_data.line_position);
               n_errors++;
            end
            if (rsp_data.is_position !== e.is_position) begin
               $error("is_position exp %0d got %0d", e.is_position, rsp_data.is_position);
               n_errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last);
               n_errors++;
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         cal_max[i] = INT_MIN;
         cal_min[i] = INT_MAX;
      end
      acc_weighted = '0;
      acc_weight = '0;
      chan_count = 5'd8;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_channel_counts();
      test_backpressure();
      test_random_frames(1300);
      drain();
      write_channels(5'($urandom_range(1, 16)));
      calm = 1;
      test_random_frames(550);
      drain();
      $display("covered %0d items, %0d results, %0d positions", n_items, n_rsps, n_positions);
      $display("including channel counts 0..31, extreme readings and a long output stall");
      if (n_errors == 0 && expected_rsps.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

### sim.f
rtl/lscp_pkg.sv
rtl/lscp_cal_ram.sv
rtl/lscp_divider.sv
rtl/line_sensor_calibrated_position_top.sv
sim/line_sensor_calibrated_position_top_tb.sv
